@@ sv/hsv_pkg.sv @@
package hsv_pkg;

    // Field widths of the pixel channels.
    localparam int HUE_W  = 9;
    localparam int CODE_W = 8;
    localparam int SEC_W  = 4;
    localparam int FRAC_W = 6;

    localparam logic [HUE_W-1:0]  HUE_FULL_TURN  = 9'd360;
    localparam logic [FRAC_W-1:0] DEG_PER_SECTOR = 6'd60;
    localparam logic [CODE_W-1:0] CODE_MAX       = 8'd255;
    // 255 * 60, the denominator of the q and t terms.
    localparam logic [13:0]       FRAC_DEN       = 14'd15300;
    // floor(2^32 / 15300), the reciprocal used for the q and t divisions.
    localparam logic [18:0]       FRAC_RECIP     = 19'd280716;

    // Queue between the classifier and the arithmetic pipeline.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [SEC_W-1:0] sector_t;

    // A classified pixel: sector and fraction of the hue, plus the raw codes.
    typedef struct packed {
        sector_t             sector;
        logic [FRAC_W-1:0]   frac;
        logic [CODE_W-1:0]   sat;
        logic [CODE_W-1:0]   val;
    } cls_t;

    // Sector codes as they select the channel mapping.
    localparam sector_t SEC_RED_RISE   = 4'd0;
    localparam sector_t SEC_GREEN_HIGH = 4'd1;
    localparam sector_t SEC_BLUE_RISE  = 4'd2;
    localparam sector_t SEC_BLUE_HIGH  = 4'd3;
    localparam sector_t SEC_RED_UP     = 4'd4;

endpackage

@@ sv/hsv_in_if.sv @@
interface hsv_in_if;
    import hsv_pkg::*;

    logic              valid;
    logic              ready;
    logic [HUE_W-1:0]  hue;
    logic [CODE_W-1:0] saturation;
    logic [CODE_W-1:0] value;

    modport source (output valid, output hue, output saturation, output value, input ready);
    modport sink   (input valid, input hue, input saturation, input value, output ready);

endinterface

@@ sv/hsv_out_if.sv @@
interface hsv_out_if;
    import hsv_pkg::*;

    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] red;
    logic [CODE_W-1:0] green;
    logic [CODE_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);

endinterface

@@ sv/hsv_front.sv @@
module hsv_front
    import hsv_pkg::*;
(
    hsv_in_if.sink     in_ch,
    input  logic       queue_full,
    output logic       push,
    output cls_t       cls
);

    logic [HUE_W-1:0] hue_wrapped;
    sector_t          sector;
    logic [HUE_W-1:0] sector_base;

    assign hue_wrapped = (in_ch.hue == HUE_FULL_TURN) ? '0 : in_ch.hue;

    // Sector by threshold compare; hues above a full turn land in sectors six to eight.
    always_comb
    begin
        sector = '0;
        for (int i = 1; i < 9; i++)
        begin
            if ({3'd0, hue_wrapped} >= 12'(i * 60))
            begin
                sector = SEC_W'(i);
            end
        end
    end

    assign sector_base = HUE_W'({5'd0, sector} * {3'd0, DEG_PER_SECTOR});

    assign cls.sector = sector;
    assign cls.frac   = FRAC_W'(hue_wrapped - sector_base);
    assign cls.sat    = in_ch.saturation;
    assign cls.val    = in_ch.value;

    assign in_ch.ready = !queue_full;
    assign push        = in_ch.valid && !queue_full;

endmodule

@@ sv/hsv_queue.sv @@
module hsv_queue
    import hsv_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cls_t push_data,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cls_t head
);

    cls_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count exceeds depth");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into a full queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from an empty queue");

endmodule

@@ sv/hsv_back.sv @@
module hsv_back
    import hsv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  cls_t       head,
    output logic       pop,
    hsv_out_if.source  out_ch
);

    logic advance;

    // Stage A: saturation times fraction and times its complement.
    logic              a_valid_reg, a_valid_next;
    sector_t           a_sector_reg;
    logic [CODE_W-1:0] a_sat_reg, a_val_reg;
    logic [13:0]       a_sr_reg, a_sr_next;
    logic [13:0]       a_st_reg, a_st_next;
    logic [FRAC_W-1:0] frac_inv;

    // Stage B: numerators of p, q and t.
    logic              b_valid_reg, b_valid_next;
    sector_t           b_sector_reg;
    logic [CODE_W-1:0] b_val_reg;
    logic [21:0]       b_nq_reg, b_nq_next;
    logic [21:0]       b_nt_reg, b_nt_next;
    logic [15:0]       b_np_reg, b_np_next;

    // Stage C: reciprocal quotient estimates, at most one low.
    logic              c_valid_reg, c_valid_next;
    sector_t           c_sector_reg;
    logic [CODE_W-1:0] c_val_reg;
    logic [21:0]       c_nq_reg, c_nt_reg;
    logic [15:0]       c_np_reg;
    logic [CODE_W-1:0] c_qe_reg, c_qe_next;
    logic [CODE_W-1:0] c_te_reg, c_te_next;
    logic [CODE_W-1:0] c_pe_reg, c_pe_next;
    logic [40:0]       q_prod, t_prod;
    logic [23:0]       p_prod;

    // Stage D: corrected terms and channel mapping into the output register.
    logic              out_valid_reg, out_valid_next;
    logic [CODE_W-1:0] red_reg, red_next;
    logic [CODE_W-1:0] green_reg, green_next;
    logic [CODE_W-1:0] blue_reg, blue_next;
    logic [21:0]       q_rem, t_rem;
    logic [15:0]       p_rem;
    logic [CODE_W-1:0] q_fix, t_fix, p_fix;

    // The whole pipeline moves together; it halts only while a result waits.
    assign advance = !out_valid_reg || out_ch.ready;
    assign pop     = advance && head_valid;

    assign frac_inv     = DEG_PER_SECTOR - head.frac;
    assign a_valid_next = head_valid;
    assign a_sr_next    = {6'd0, head.sat} * {8'd0, head.frac};
    assign a_st_next    = {6'd0, head.sat} * {8'd0, frac_inv};

    assign b_valid_next = a_valid_reg;
    assign b_nq_next    = {14'd0, a_val_reg} * {8'd0, FRAC_DEN - a_sr_reg};
    assign b_nt_next    = {14'd0, a_val_reg} * {8'd0, FRAC_DEN - a_st_reg};
    assign b_np_next    = {8'd0, a_val_reg} * {8'd0, CODE_MAX - a_sat_reg};

    assign c_valid_next = b_valid_reg;
    assign q_prod       = {19'd0, b_nq_reg} * {22'd0, FRAC_RECIP};
    assign t_prod       = {19'd0, b_nt_reg} * {22'd0, FRAC_RECIP};
    assign p_prod       = {8'd0, b_np_reg} + {b_np_reg, 8'd0};
    assign c_qe_next    = q_prod[39:32];
    assign c_te_next    = t_prod[39:32];
    assign c_pe_next    = p_prod[23:16];

    assign q_rem = c_nq_reg - {14'd0, c_qe_reg} * {8'd0, FRAC_DEN};
    assign t_rem = c_nt_reg - {14'd0, c_te_reg} * {8'd0, FRAC_DEN};
    assign p_rem = c_np_reg - {8'd0, c_pe_reg} * {8'd0, CODE_MAX};
    assign q_fix = (q_rem >= {8'd0, FRAC_DEN}) ? c_qe_reg + 1'b1 : c_qe_reg;
    assign t_fix = (t_rem >= {8'd0, FRAC_DEN}) ? c_te_reg + 1'b1 : c_te_reg;
    assign p_fix = (p_rem >= {8'd0, CODE_MAX}) ? c_pe_reg + 1'b1 : c_pe_reg;

    assign out_valid_next = c_valid_reg;

    always_comb
    begin
        unique case (c_sector_reg)
            SEC_RED_RISE:
            begin
                red_next = c_val_reg; green_next = t_fix; blue_next = p_fix;
            end
            SEC_GREEN_HIGH:
            begin
                red_next = q_fix; green_next = c_val_reg; blue_next = p_fix;
            end
            SEC_BLUE_RISE:
            begin
                red_next = p_fix; green_next = c_val_reg; blue_next = t_fix;
            end
            SEC_BLUE_HIGH:
            begin
                red_next = p_fix; green_next = q_fix; blue_next = c_val_reg;
            end
            SEC_RED_UP:
            begin
                red_next = t_fix; green_next = p_fix; blue_next = c_val_reg;
            end
            default:
            begin
                red_next = c_val_reg; green_next = p_fix; blue_next = q_fix;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg   <= a_valid_next;
            b_valid_reg   <= b_valid_next;
            c_valid_reg   <= c_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_sector_reg <= head.sector;
            a_sat_reg    <= head.sat;
            a_val_reg    <= head.val;
            a_sr_reg     <= a_sr_next;
            a_st_reg     <= a_st_next;

            b_sector_reg <= a_sector_reg;
            b_val_reg    <= a_val_reg;
            b_nq_reg     <= b_nq_next;
            b_nt_reg     <= b_nt_next;
            b_np_reg     <= b_np_next;

            c_sector_reg <= b_sector_reg;
            c_val_reg    <= b_val_reg;
            c_nq_reg     <= b_nq_reg;
            c_nt_reg     <= b_nt_reg;
            c_np_reg     <= b_np_reg;
            c_qe_reg     <= c_qe_next;
            c_te_reg     <= c_te_next;
            c_pe_reg     <= c_pe_next;

            red_reg      <= red_next;
            green_reg    <= green_next;
            blue_reg     <= blue_next;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.red   = red_reg;
    assign out_ch.green = green_reg;
    assign out_ch.blue  = blue_reg;

    a_est_not_above_value: assert property (@(posedge clk) disable iff (!rst_n)
        c_valid_reg |-> (c_qe_reg <= c_val_reg) && (c_te_reg <= c_val_reg)
                        && (c_pe_reg <= c_val_reg))
        else $error("quotient estimate exceeds value");

    a_qt_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        c_valid_reg |-> (q_rem < ({8'd0, FRAC_DEN} << 1)) && (t_rem < ({8'd0, FRAC_DEN} << 1)))
        else $error("q or t estimate off by more than one");

    a_p_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        c_valid_reg |-> (p_rem < ({8'd0, CODE_MAX} << 1)))
        else $error("p estimate off by more than one");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready) |=> out_valid_reg && $stable(red_reg)
                                             && $stable(green_reg) && $stable(blue_reg))
        else $error("result changed while stalled");

endmodule

@@ sv/hsv_to_rgb_converter_core.sv @@
// HSV to RGB pixel converter.
//
// Pixels arrive on in_ch as a transaction carrying hue (whole degrees, 0 to 360,
// where 360 wraps to 0), saturation and value (8-bit codes for code/255).
// Each accepted transaction yields exactly one transaction on out_ch carrying
// 8-bit red, green and blue, every channel truncated toward zero.
//
// The front classifier splits the hue into sector and fraction and writes the
// pixel into a two-entry queue. The back part is a four-stage arithmetic
// pipeline: products of saturation and fraction, the numerators, reciprocal
// quotient estimates, then a one-step correction and the sector mapping into
// the output register. One pixel per cycle is sustained while out_ch does not
// stall; the rate is set by the single-issue pipeline, which takes one queue
// entry per cycle.
//
// When out_ch stalls, the whole pipeline holds and the result stays on out_ch;
// the queue keeps accepting until it fills, then in_ch.ready drops.
// Reset (rst_n low, asynchronous) empties the queue and the pipeline; no state
// beyond that exists.
module hsv_to_rgb_converter_core
    import hsv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    hsv_in_if.sink    in_ch,
    hsv_out_if.source out_ch
);

    cls_t front_cls;
    cls_t queue_head;
    logic front_push;
    logic queue_full;
    logic queue_head_valid;
    logic back_pop;

    hsv_front u_front (
        .in_ch      (in_ch),
        .queue_full (queue_full),
        .push       (front_push),
        .cls        (front_cls)
    );

    hsv_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (front_push),
        .push_data  (front_cls),
        .full       (queue_full),
        .pop        (back_pop),
        .head_valid (queue_head_valid),
        .head       (queue_head)
    );

    hsv_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (queue_head_valid),
        .head       (queue_head),
        .pop        (back_pop),
        .out_ch     (out_ch)
    );

endmodule
